// ===== rtl/core/afu_pkg.sv =====
// afu_pkg: shared constants, function codes, pipeline context type and the
// sigmoid table builder for the activation function unit.
// No dependencies; every other file of the block uses it.
package afu_pkg;

    // data format
    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 12;

    // sigmoid table geometry over [-8,8]
    localparam int SEG     = 256;
    localparam int IDX_W   = $clog2(SEG);
    localparam int TFRAC_W = 32 - IDX_W;
    localparam int SIG_W   = 31;
    localparam int ARG_W   = 33;

    // pipeline depth and internal widths
    localparam int NS     = 17;
    localparam int PRE_W  = 50;
    localparam int SUM_W  = 51;

    // fixed-point constants
    localparam logic signed [15:0] X_CLAMP = 16'sd16384;
    localparam logic signed [31:0] ONE30   = 32'sd1073741824;
    localparam logic signed [27:0] K30_Q30 = 28'sd48012366;
    localparam logic        [27:0] K30X3   = 28'd144037098;
    localparam logic signed [30:0] C30_Q30 = 31'sd856722024;
    localparam longint unsigned    EINV32  = 64'd1580030169;
    localparam logic        [15:0] SLOPE_RESET = 16'd655;

    // function codes
    typedef enum logic [3:0] {
        FN_RELU      = 4'd0,
        FN_RELU_D    = 4'd1,
        FN_LEAKY     = 4'd2,
        FN_LEAKY_D   = 4'd3,
        FN_SIGMOID   = 4'd4,
        FN_SIGMOID_D = 4'd5,
        FN_TANH      = 4'd6,
        FN_TANH_D    = 4'd7,
        FN_GELU      = 4'd8,
        FN_GELU_D    = 4'd9,
        FN_SWISH     = 4'd10,
        FN_SWISH_D   = 4'd11
    } afu_func_t;

    // per-transaction context carried down the pipeline
    typedef struct packed {
        afu_func_t          func;
        logic signed [15:0] x;
        logic signed [15:0] xc;
    } afu_ctx_t;

    // final rounding shift for each function
    function automatic logic [4:0] round_shift(afu_func_t f);
        logic [4:0] sh;
        case (f)
            FN_LEAKY, FN_LEAKY_D:     sh = 5'd16;
            FN_SIGMOID, FN_TANH:      sh = 5'(30 - FRAC_BITS);
            FN_GELU_D:                sh = 5'(30 - FRAC_BITS);
            FN_SIGMOID_D, FN_TANH_D:  sh = 5'(FRAC_BITS);
            FN_GELU:                  sh = 5'd31;
            FN_SWISH, FN_SWISH_D:     sh = 5'd30;
            default:                  sh = 5'd0;
        endcase
        return sh;
    endfunction

    // unsigned 64-bit quotient by shift and subtract, floor
    function automatic longint unsigned div_u64(longint unsigned num,
                                                longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sigmoid(-8 + 16k/SEG) in Q30, integer-only Taylor series for exp
    function automatic logic [SIG_W-1:0] sig_entry(int k);
        longint unsigned a;
        longint unsigned b;
        longint unsigned num;
        longint unsigned n;
        longint unsigned f;
        longint unsigned term;
        longint unsigned e;
        longint unsigned sp;
        longint          sum;
        a = 64'(16 * k);
        b = 64'(8 * SEG);
        num = (a >= b) ? a - b : b - a;
        n = num / SEG;
        f = ((num % SEG) << 32) / SEG;
        sum = 64'sd1 <<< 32;
        term = 64'd1 << 32;
        for (int i = 1; i <= 16; i++)
        begin
            term = div_u64((term * f) >> 32, 64'(i));
            if (i % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        e = $unsigned(sum);
        for (longint unsigned j = 0; j < n; j++)
        begin
            e = (e * EINV32) >> 32;
        end
        sp = div_u64(64'd1 << 62, (64'd1 << 32) + e);
        return SIG_W'((a < b) ? (64'd1 << 30) - sp : sp);
    endfunction

endpackage

// ===== rtl/core/afu_if.sv =====
// afu_if: valid/ready channel interfaces for operands and results.
// Depends on afu_pkg for the data width.
interface afu_in_if;
    logic                                valid;
    logic                                ready;
    logic [3:0]                          func;
    logic signed [afu_pkg::DATA_W-1:0]   x_value;

    modport source (output valid, func, x_value, input ready);
    modport sink   (input valid, func, x_value, output ready);
endinterface

interface afu_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [afu_pkg::DATA_W-1:0]   y_value;
    logic                                saturated;

    modport source (output valid, y_value, saturated, input ready);
    modport sink   (input valid, y_value, saturated, output ready);
endinterface

// ===== rtl/core/activation_function_unit.sv =====
// Activation function unit: takes one Q4.12 operand and a function code per
// transaction and returns the rounded, saturated Q4.12 result with a clip flag.
// The unit is a 17-stage pipeline: one transaction is accepted every clock
// while the output is not held, and each result is valid at the output once
// it has passed through all stages. When the result at the output is not taken,
// the whole pipeline holds and input ready drops in that cycle. The leaky
// slope register is loaded through cfg_write and cfg_data and should only
// change while no transaction is in flight.
// Depends on afu_pkg, afu_if and afu_sigmoid.
module activation_function_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [15:0]          cfg_data,
    afu_in_if.sink               in_ch,
    afu_out_if.source            out_ch
);
    import afu_pkg::*;

    logic [15:0]                slope_reg;
    logic [NS:1]                vld_reg;
    logic                       adv;
    afu_ctx_t                   ctx_reg [1:NS];
    afu_ctx_t                   ctx_next;

    logic [28:0]                sq2_reg;
    logic signed [33:0]         lin2_reg;
    logic signed [37:0]         c3_reg;
    logic [31:0]                kx3_reg;
    logic signed [63:0]         kc4_reg;
    logic [32:0]                dpin4_reg;
    logic signed [33:0]         inner5_reg;
    logic [62:0]                dprod5_reg;
    logic signed [63:0]         ci6_reg;
    logic [32:0]                dpoly_reg [6:13];
    logic [ARG_W-1:0]           u7_reg;
    logic signed [31:0]         sig10;
    logic signed [31:0]         s_reg [11:14];
    logic signed [63:0]         m11_reg;
    logic signed [33:0]         r12_reg;
    logic signed [49:0]         m13_reg;
    logic signed [67:0]         p14_reg;
    logic signed [PRE_W-1:0]    pre_reg [3:15];
    logic signed [SUM_W-1:0]    sum16_reg;
    logic signed [15:0]         y_reg;
    logic                       sat_reg;

    logic signed [31:0]         sq_full;
    logic signed [17:0]         lin_b;
    logic signed [33:0]         lin_next;
    logic signed [37:0]         c3_next;
    logic [31:0]                kx_next;
    logic signed [33:0]         inner_next;
    logic signed [35:0]         arg_a;
    logic [ARG_W-1:0]           u_next;
    logic signed [31:0]         s11;
    logic signed [31:0]         t11;
    logic signed [33:0]         ma;
    logic signed [33:0]         mb;
    logic signed [33:0]         q12;
    logic signed [33:0]         r12_next;
    logic signed [15:0]         m13_a;
    logic signed [PRE_W-1:0]    pre_next [3:15];
    logic [4:0]                 sh16;
    logic [4:0]                 sh17;
    logic signed [SUM_W-1:0]    half16;
    logic signed [SUM_W-1:0]    shifted17;
    logic signed [15:0]         y_next;
    logic                       sat_next;

    localparam logic signed [35:0]      ARG_MAX = 36'sd2147483648;
    localparam logic signed [SUM_W-1:0] Y_MAX   = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] Y_MIN   = -Y_MAX - SUM_W'(1);
    localparam logic signed [15:0]      ONE_Q   = 16'sd4096;

    // leaky slope register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slope_reg <= SLOPE_RESET;
        else if (cfg_write)
            slope_reg <= cfg_data;
    end

    // whole pipeline advances unless the output is held
    assign adv = !vld_reg[NS] || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-1:1], in_ch.valid};
    end

    // operand capture with gelu clamp to [-4,4]
    always_comb
    begin
        ctx_next.func = afu_func_t'(in_ch.func);
        ctx_next.x    = in_ch.x_value;
        if (in_ch.x_value > X_CLAMP)
            ctx_next.xc = X_CLAMP;
        else if (in_ch.x_value < -X_CLAMP)
            ctx_next.xc = -X_CLAMP;
        else
            ctx_next.xc = in_ch.x_value;
    end

    // stage 2: square and the simple-function product
    always_comb
    begin
        sq_full = 32'(ctx_reg[1].xc) * 32'(ctx_reg[1].xc);
        case (ctx_reg[1].func)
            FN_LEAKY:     lin_b = $signed({2'b00, slope_reg});
            FN_SIGMOID_D: lin_b = 18'(ONE_Q) - 18'(ctx_reg[1].x);
            default:      lin_b = 18'(ctx_reg[1].x);
        endcase
        lin_next = 34'(ctx_reg[1].x) * 34'(lin_b);
    end

    // stage 3: cube and derivative polynomial term
    always_comb
    begin
        c3_next = 38'((46'($signed({1'b0, sq2_reg})) * 46'(ctx_reg[2].xc)) >>> 8);
        kx_next = 32'((57'(K30X3) * 57'(sq2_reg)) >> 24);
    end

    // stage 5: gelu inner argument
    assign inner_next = (34'(ctx_reg[4].xc) <<< 16) + 34'(kc4_reg >>> 30);

    // stage 7: sigmoid argument select and clamp to [-8,8]
    always_comb
    begin
        case (ctx_reg[6].func)
            FN_GELU, FN_GELU_D: arg_a = 36'(ci6_reg >>> 30) <<< 1;
            FN_TANH:            arg_a = 36'(ctx_reg[6].x) <<< 17;
            default:            arg_a = 36'(ctx_reg[6].x) <<< 16;
        endcase
        if (arg_a > ARG_MAX)
            arg_a = ARG_MAX;
        else if (arg_a < -ARG_MAX)
            arg_a = -ARG_MAX;
        u_next = ARG_W'(arg_a + ARG_MAX);
    end

    // stage 11: shared multiplier on the sigmoid output
    always_comb
    begin
        s11 = sig10;
        t11 = (s11 <<< 1) - ONE30;
        case (ctx_reg[10].func)
            FN_GELU:
            begin
                ma = 34'(ctx_reg[10].x);
                mb = 34'(s11) <<< 1;
            end
            FN_GELU_D:
            begin
                ma = 34'(t11);
                mb = 34'(t11);
            end
            FN_SWISH_D:
            begin
                ma = 34'(s11);
                mb = 34'(ONE30) - 34'(s11);
            end
            default:
            begin
                ma = 34'(ctx_reg[10].x);
                mb = 34'(s11);
            end
        endcase
    end

    // stage 12/13: sech^2 or s(1-s), then times x
    always_comb
    begin
        q12 = 34'(m11_reg >>> 30);
        if (ctx_reg[11].func == FN_GELU_D)
            r12_next = 34'(ONE30) - q12;
        else
            r12_next = q12;
        if (ctx_reg[12].func == FN_GELU_D)
            m13_a = ctx_reg[12].xc;
        else
            m13_a = ctx_reg[12].x;
    end

    // pre-rounding value per function, overwritten where it becomes known
    always_comb
    begin
        for (int k = 4; k <= 15; k++)
        begin
            pre_next[k] = pre_reg[k-1];
        end
        case (ctx_reg[2].func)
            FN_RELU:
                pre_next[3] = (ctx_reg[2].x > 0) ? PRE_W'(ctx_reg[2].x) : '0;
            FN_RELU_D:
                pre_next[3] = (ctx_reg[2].x > 0) ? PRE_W'(ONE_Q) : '0;
            FN_LEAKY:
                pre_next[3] = (ctx_reg[2].x > 0) ? (PRE_W'(ctx_reg[2].x) <<< 16)
                                                 : PRE_W'(lin2_reg);
            FN_LEAKY_D:
                pre_next[3] = (ctx_reg[2].x > 0) ? (PRE_W'(ONE_Q) <<< 16)
                                                 : (PRE_W'({1'b0, slope_reg}) <<< 12);
            FN_SIGMOID_D:
                pre_next[3] = PRE_W'(lin2_reg);
            FN_TANH_D:
                pre_next[3] = (PRE_W'(1) <<< 24) - PRE_W'(lin2_reg);
            default:
                pre_next[3] = '0;
        endcase
        case (ctx_reg[10].func)
            FN_SIGMOID: pre_next[11] = PRE_W'(s11);
            FN_TANH:    pre_next[11] = PRE_W'(t11);
            default:    pre_next[11] = pre_reg[10];
        endcase
        case (ctx_reg[11].func)
            FN_GELU, FN_SWISH: pre_next[12] = PRE_W'(m11_reg);
            default:           pre_next[12] = pre_reg[11];
        endcase
        if (ctx_reg[13].func == FN_SWISH_D)
            pre_next[14] = (PRE_W'(s_reg[13]) <<< 12) + PRE_W'(m13_reg);
        if (ctx_reg[14].func == FN_GELU_D)
            pre_next[15] = PRE_W'(s_reg[14]) + PRE_W'(p14_reg >>> 29);
    end

    // stage 16/17: round to nearest, then shift and saturate
    always_comb
    begin
        sh16 = round_shift(ctx_reg[15].func);
        if (sh16 == 5'd0)
            half16 = '0;
        else
            half16 = SUM_W'(1) <<< (sh16 - 5'd1);
        sh17 = round_shift(ctx_reg[16].func);
        shifted17 = sum16_reg >>> sh17;
        if (shifted17 > Y_MAX)
        begin
            y_next   = 16'sh7fff;
            sat_next = 1'b1;
        end
        else if (shifted17 < Y_MIN)
        begin
            y_next   = -16'sh7fff - 16'sd1;
            sat_next = 1'b1;
        end
        else
        begin
            y_next   = 16'(shifted17);
            sat_next = 1'b0;
        end
    end

    // pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg[1] <= ctx_next;
            for (int k = 2; k <= NS; k++)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
            sq2_reg    <= 29'(sq_full);
            lin2_reg   <= lin_next;
            c3_reg     <= c3_next;
            kx3_reg    <= kx_next;
            kc4_reg    <= 64'(K30_Q30) * 64'(c3_reg);
            dpin4_reg  <= 33'(ONE30) + 33'(kx3_reg);
            inner5_reg <= inner_next;
            dprod5_reg <= 63'($unsigned(C30_Q30)) * 63'(dpin4_reg);
            ci6_reg    <= 64'(C30_Q30) * 64'(inner5_reg);
            dpoly_reg[6] <= 33'(dprod5_reg >> 30);
            for (int k = 7; k <= 13; k++)
            begin
                dpoly_reg[k] <= dpoly_reg[k-1];
            end
            u7_reg     <= u_next;
            s_reg[11]  <= s11;
            for (int k = 12; k <= 14; k++)
            begin
                s_reg[k] <= s_reg[k-1];
            end
            m11_reg    <= 64'(ma) * 64'(mb);
            r12_reg    <= r12_next;
            m13_reg    <= 50'(m13_a) * 50'(r12_reg);
            p14_reg    <= 68'(m13_reg >>> 14) * 68'($signed({1'b0, dpoly_reg[13]}));
            for (int k = 3; k <= 15; k++)
            begin
                pre_reg[k] <= pre_next[k];
            end
            sum16_reg  <= SUM_W'(pre_reg[15]) + half16;
            y_reg      <= y_next;
            sat_reg    <= sat_next;
        end
    end

    // stages 8 to 10: table sigmoid
    afu_sigmoid u_sigmoid (
        .clk (clk),
        .en  (adv),
        .arg (u7_reg),
        .sig (sig10)
    );

    // result transaction
    assign out_ch.valid     = vld_reg[NS];
    assign out_ch.y_value   = y_reg;
    assign out_ch.saturated = sat_reg;

    // undefined codes give a clean zero
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS] && (ctx_reg[NS].func > FN_SWISH_D) |-> (y_reg == '0) && !sat_reg)
        else $error("undefined function code produced a nonzero result");

    // clip flag only at the range ends
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS] && sat_reg |-> (y_reg == 16'sh7fff) || (y_reg == -16'sh7fff - 16'sd1))
        else $error("saturation flag set on an in-range result");

    // a held output freezes every stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while output was held");

    // relu never goes negative
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS] && (ctx_reg[NS].func == FN_RELU) |-> !y_reg[15])
        else $error("relu produced a negative result");

endmodule

// ===== rtl/core/afu_sigmoid.sv =====
// afu_sigmoid: three-stage piecewise-linear sigmoid (lookup, multiply, add).
// Depends on afu_pkg for the table builder and widths.
module afu_sigmoid (
    input  logic                         clk,
    input  logic                         en,
    input  logic [afu_pkg::ARG_W-1:0]    arg,
    output logic signed [31:0]           sig
);
    import afu_pkg::*;

    localparam int PROD_W = 32 + TFRAC_W + 1;

    logic [SIG_W-1:0]           tab [0:SEG];
    logic [IDX_W:0]             idx_lo;
    logic [IDX_W:0]             idx_hi;
    logic [SIG_W-1:0]           lo_next;
    logic [SIG_W-1:0]           hi_next;
    logic [SIG_W-1:0]           lo1_reg;
    logic signed [31:0]         diff1_reg;
    logic [TFRAC_W-1:0]         frac1_reg;
    logic [SIG_W-1:0]           lo2_reg;
    logic signed [PROD_W-1:0]   prod2_reg;
    logic signed [31:0]         sig_reg;

    // constant segment table
    for (genvar g = 0; g <= SEG; g++)
    begin : g_tab
        localparam logic [SIG_W-1:0] ENTRY = sig_entry(g);
        assign tab[g] = ENTRY;
    end

    // segment endpoints, top end of range pinned to the last entry
    always_comb
    begin
        idx_lo = {1'b0, arg[31 -: IDX_W]};
        idx_hi = idx_lo + 1'b1;
        if (arg[32])
        begin
            lo_next = tab[SEG];
            hi_next = tab[SEG];
        end
        else
        begin
            lo_next = tab[idx_lo];
            hi_next = tab[idx_hi];
        end
    end

    // lookup, slope times fraction, then add
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo1_reg   <= lo_next;
            diff1_reg <= $signed({1'b0, hi_next}) - $signed({1'b0, lo_next});
            frac1_reg <= arg[TFRAC_W-1:0];
            lo2_reg   <= lo1_reg;
            prod2_reg <= PROD_W'(diff1_reg) * PROD_W'($signed({1'b0, frac1_reg}));
            sig_reg   <= 32'($signed({1'b0, lo2_reg})) + 32'(prod2_reg >>> TFRAC_W);
        end
    end

    assign sig = sig_reg;

endmodule

// ===== verif/activation_function_unit_tb.sv =====
// activation_function_unit_tb: self-checking testbench for the activation unit.
// Drives operands with random idling, predicts every result with a local
// fixed-point model, and checks results in order. Depends on afu_pkg and afu_if.
`timescale 1ns / 1ps

module activation_function_unit_tb;
    import afu_pkg::*;

    localparam int  CLK_HALF  = 6;
    localparam int  LIMIT     = 400000;
    localparam int  DRAIN     = 24;
    localparam longint EIGHT_Q28 = 64'sd1 <<< 31;
    localparam longint FOUR_Q28  = 64'sd1 <<< 30;
    localparam longint ONE_Q30   = 64'sd1 <<< 30;
    localparam longint GELU_K    = 64'sd48012366;
    localparam longint GELU_C    = 64'sd856722024;
    localparam longint unsigned E_INV = 64'd1580030169;

    typedef struct {
        logic signed [15:0] y;
        logic               sat;
    } act_result_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [15:0] cfg_data;

    afu_in_if  in_ch ();
    afu_out_if out_ch ();

    activation_function_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    longint      sig_tab [0:256];
    logic [15:0] slope_reg;
    act_result_t result_q [$];
    int          err_count;
    int          cycle_count;
    bit          idle_en;
    int          stall_left;

    // clock
    always #(CLK_HALF) clk = ~clk;

    // sigmoid breakpoints in Q30, integer exp series
    function automatic void build_sig_tab();
        longint unsigned a, b, num, n, f, term, e, sp;
        longint sum;
        for (int k = 0; k <= 256; k++)
        begin
            a = 64'(16 * k);
            b = 64'(8 * 256);
            num = (a >= b) ? a - b : b - a;
            n = num / 256;
            f = ((num % 256) << 32) / 256;
            sum = 64'sd1 <<< 32;
            term = 64'd1 << 32;
            for (int i = 1; i <= 16; i++)
            begin
                term = ((term * f) >> 32) / 64'(i);
                if (i % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            e = longint'(sum);
            for (longint unsigned j = 0; j < n; j++)
                e = (e * E_INV) >> 32;
            sp = (64'd1 << 62) / ((64'd1 << 32) + e);
            sig_tab[k] = longint'((a < b) ? (64'd1 << 30) - sp : sp);
        end
    endfunction

    // sigmoid of a Q28 argument, Q30 result
    function automatic longint sigmoid_q30(longint arg);
        longint a, rem, lo, diff;
        longint unsigned p, idx;
        a = arg;
        if (a < -EIGHT_Q28) a = -EIGHT_Q28;
        if (a > EIGHT_Q28) a = EIGHT_Q28;
        p = longint'(a + EIGHT_Q28) * 64'd256;
        idx = p >> 32;
        rem = longint'(p & 64'hFFFF_FFFF);
        if (idx >= 256)
            return sig_tab[256];
        lo = sig_tab[idx];
        diff = sig_tab[idx + 1] - lo;
        return lo + ((diff * rem) >>> 32);
    endfunction

    function automatic longint round_q(longint v, int s);
        if (s == 0)
            return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic act_result_t clip_q(longint v);
        act_result_t r;
        r.sat = 1'b0;
        if (v > 32767) begin v = 32767; r.sat = 1'b1; end
        if (v < -32768) begin v = -32768; r.sat = 1'b1; end
        r.y = 16'(v);
        return r;
    endfunction

    // expected result of one operand
    function automatic act_result_t activation_of(logic [3:0] fn, logic signed [15:0] xv);
        longint x, one, x28, xc, s, t, x2, inner, sech2, dpoly, v;
        act_result_t r;
        x = longint'(xv);
        one = 64'sd4096;
        x28 = x * 65536;
        xc = x28 > FOUR_Q28 ? FOUR_Q28 : (x28 < -FOUR_Q28 ? -FOUR_Q28 : x28);
        x2 = (xc * xc) >>> 28;
        inner = xc + ((GELU_K * ((x2 * xc) >>> 28)) >>> 30);
        inner = (GELU_C * inner) >>> 30;
        t = 2 * sigmoid_q30(2 * inner) - ONE_Q30;
        s = sigmoid_q30(x28);
        case (fn)
            FN_RELU:      r = clip_q(x > 0 ? x : 0);
            FN_RELU_D:    r = clip_q(x > 0 ? one : 0);
            FN_LEAKY:     r = clip_q(x > 0 ? x : round_q(x * longint'(slope_reg), 16));
            FN_LEAKY_D:   r = clip_q(x > 0 ? one : round_q(longint'(slope_reg) * one, 16));
            FN_SIGMOID:   r = clip_q(round_q(s, 18));
            FN_SIGMOID_D: r = clip_q(round_q(x * (one - x), 12));
            FN_TANH:      r = clip_q(round_q(2 * sigmoid_q30(2 * x28) - ONE_Q30, 18));
            FN_TANH_D:    r = clip_q(round_q(one * one - x * x, 12));
            FN_GELU:      r = clip_q(round_q(x * (ONE_Q30 + t), 31));
            FN_GELU_D:
            begin
                sech2 = ONE_Q30 - ((t * t) >>> 30);
                dpoly = (GELU_C * (ONE_Q30 + ((3 * GELU_K * x2) >>> 28))) >>> 30;
                v = ((ONE_Q30 + t) >>> 1)
                    + (((((xc * sech2) >>> 30) * dpoly) >>> 28) >>> 1);
                r = clip_q(round_q(v, 18));
            end
            FN_SWISH:     r = clip_q(round_q(x * s, 30));
            FN_SWISH_D:
            begin
                v = s * one + x * ((s * (ONE_Q30 - s)) >>> 30);
                r = clip_q(round_q(v, 30));
            end
            default:
            begin
                r.y = '0;
                r.sat = 1'b0;
            end
        endcase
        return r;
    endfunction

    // send one operand, optionally after an idle burst
    task automatic send_operand(logic [3:0] fn, logic signed [15:0] xv);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= fn;
        in_ch.x_value <= xv;
        do @(posedge clk); while (!in_ch.ready);
        result_q.push_back(activation_of(fn, xv));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_slope(logic [15:0] val);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        slope_reg = val;
        cfg_write <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_operand();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'(int'($urandom_range(0, 4096)) - 2048);
            default: return 16'(int'($urandom_range(0, 65535)) - 32768);
        endcase
    endfunction

    function automatic logic [3:0] rand_func();
        if ($urandom_range(0, 19) == 0)
            return 4'($urandom_range(12, 15));
        return 4'($urandom_range(0, 11));
    endfunction

    // directed extremes and special cases for each defined code and two undefined codes
    task automatic test_directed();
        send_operand(FN_RELU, -16'sd32768);
        send_operand(FN_RELU, 16'sd32767);
        send_operand(FN_RELU_D, 16'sd0);
        send_operand(FN_RELU_D, 16'sd1);
        send_operand(FN_LEAKY, -16'sd32768);
        send_operand(FN_LEAKY, 16'sd0);
        send_operand(FN_LEAKY_D, 16'sd0);
        send_operand(FN_SIGMOID, 16'sd32767);
        send_operand(FN_SIGMOID, -16'sd32768);
        send_operand(FN_SIGMOID, 16'sd0);
        send_operand(FN_SIGMOID_D, 16'sd32767);
        send_operand(FN_SIGMOID_D, -16'sd32768);
        send_operand(FN_TANH, 16'sd16384);
        send_operand(FN_TANH, -16'sd4096);
        send_operand(FN_TANH_D, -16'sd32768);
        send_operand(FN_TANH_D, 16'sd4096);
        send_operand(FN_GELU, 16'sd32767);
        send_operand(FN_GELU, -16'sd20000);
        send_operand(FN_GELU_D, 16'sd20000);
        send_operand(FN_GELU_D, -16'sd1);
        send_operand(FN_SWISH, 16'sd32767);
        send_operand(FN_SWISH_D, -16'sd32768);
        send_operand(4'd12, 16'sd32767);
        send_operand(4'd15, -16'sd1);
    endtask

    // leaky slope settings, extremes first
    task automatic test_slope_settings();
        logic [15:0] slopes [4];
        slopes = '{16'd0, 16'd65535, 16'd1, 16'($urandom)};
        foreach (slopes[i])
        begin
            write_slope(slopes[i]);
            for (int n = 0; n < 12; n++)
                send_operand(n % 2 ? FN_LEAKY_D : FN_LEAKY, rand_operand());
            send_operand(FN_LEAKY, -16'sd32768);
        end
        write_slope(SLOPE_RESET);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
            send_operand(rand_func(), rand_operand());
    endtask

    // back-to-back stream with no idling on either side
    task automatic test_streaming();
        idle_en = 1'b0;
        test_random(60);
    endtask

    // output ready with random stall bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 18);
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        act_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (result_q.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result y=%0d sat=%0b", out_ch.y_value,
                             out_ch.saturated);
            end
            else
            begin
                want = result_q.pop_front();
                if (want.y !== out_ch.y_value || want.sat !== out_ch.saturated)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: expected y=%0d sat=%0b, got y=%0d sat=%0b",
                                 want.y, want.sat, out_ch.y_value, out_ch.saturated);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.func = '0;
        in_ch.x_value = '0;
        idle_en = 1'b1;
        slope_reg = SLOPE_RESET;
        build_sig_tab();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_slope_settings();
        test_random(264);
        test_streaming();
        wait_drained();

        if (err_count == 0 && result_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/afu_pkg.sv
rtl/core/afu_if.sv
rtl/core/afu_sigmoid.sv
rtl/core/activation_function_unit.sv
verif/activation_function_unit_tb.sv
